### hw/rtl/ccbd_pkg.sv
// Package for the converter command byte decoder.
// Holds word types, opcodes, command states and size constants; no dependencies.
`default_nettype none

package ccbd_pkg;

  localparam int unsigned NumCoefsDef = 5;
  localparam int unsigned AdcBits     = 10;
  localparam int unsigned CountW      = 4;
  localparam int unsigned CoefIdxW    = 3;

  localparam logic [7:0] OpLoad = 8'hA0;
  localparam logic [7:0] OpOff  = 8'hA1;
  localparam logic [7:0] OpRef  = 8'hA2;
  localparam logic [7:0] OpRead = 8'hA3;

  typedef enum logic [1:0] {
    CMD_IDLE = 2'd0,
    CMD_LOAD = 2'd1,
    CMD_REF  = 2'd2,
    CMD_READ = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [7:0]         rx_byte;
    logic [AdcBits-1:0] adc_sample;
  } in_word_t;

  typedef struct packed {
    logic                tx_valid;
    logic [7:0]          tx_byte;
    logic                coef_write;
    logic [CoefIdxW-1:0] coef_index;
    logic [15:0]         coef_value;
    logic                ref_write;
    logic [15:0]         ref_value;
    logic                pwm_enable;
  } out_word_t;

endpackage

`default_nettype wire

### hw/rtl/converter_command_byte_decoder_top.sv
// Each word goes into the input register, its result into the result register.
// Throughput: one word per cycle; the input register and the result register
// each advance while the stage after them is empty or being taken.
// Reset: command state idle, counters and low byte cleared, PWM off.
// Depends on ccbd_pkg.
`default_nettype none

module converter_command_byte_decoder_top #(
  parameter int unsigned NUM_COEFS = ccbd_pkg::NumCoefsDef
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  ccbd_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output ccbd_pkg::out_word_t out_word_o
);

  localparam logic [ccbd_pkg::CountW-1:0] LastCnt = ccbd_pkg::CountW'(2 * NUM_COEFS);

  // input register
  logic               s1_valid_q;
  ccbd_pkg::in_word_t s1_word_q;
  // result register
  logic                out_valid_q;
  ccbd_pkg::out_word_t out_word_q;

  // decoder state
  ccbd_pkg::cmd_e                cmd_q, cmd_d;
  logic [ccbd_pkg::CountW-1:0]   byte_cnt_q, byte_cnt_d;
  logic [ccbd_pkg::CoefIdxW-1:0] coef_cnt_q, coef_cnt_d;
  logic [7:0]                    low_q, low_d;
  logic                          pwm_q, pwm_d;
  ccbd_pkg::out_word_t           res;

  logic out_free, s1_move, in_fire;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_d      = cmd_q;
    byte_cnt_d = byte_cnt_q;
    coef_cnt_d = coef_cnt_q;
    low_d      = low_q;
    pwm_d      = pwm_q;
    res        = '0;
    case (cmd_q)
      ccbd_pkg::CMD_IDLE: begin
        if (s1_word_q.rx_byte == ccbd_pkg::OpLoad) begin
          cmd_d        = ccbd_pkg::CMD_LOAD;
          byte_cnt_d   = ccbd_pkg::CountW'(1);
          coef_cnt_d   = '0;
          res.tx_valid = 1'b1;
          res.tx_byte  = ccbd_pkg::OpLoad;
        end else if (s1_word_q.rx_byte == ccbd_pkg::OpOff) begin
          pwm_d = 1'b0;
        end else if (s1_word_q.rx_byte == ccbd_pkg::OpRef) begin
          cmd_d        = ccbd_pkg::CMD_REF;
          byte_cnt_d   = ccbd_pkg::CountW'(1);
          res.tx_valid = 1'b1;
          res.tx_byte  = ccbd_pkg::OpRef;
        end else if (s1_word_q.rx_byte == ccbd_pkg::OpRead) begin
          cmd_d        = ccbd_pkg::CMD_READ;
          byte_cnt_d   = ccbd_pkg::CountW'(1);
          res.tx_valid = 1'b1;
          // both bytes come from the same sample, zero while the PWM is off
          if (pwm_q) begin
            res.tx_byte = 8'(s1_word_q.adc_sample >> 8);
            low_d       = s1_word_q.adc_sample[7:0];
          end else begin
            res.tx_byte = '0;
            low_d       = '0;
          end
        end
      end
      ccbd_pkg::CMD_LOAD: begin
        if (byte_cnt_q != '0 && byte_cnt_q <= LastCnt) begin
          if (byte_cnt_q[0]) begin
            low_d = s1_word_q.rx_byte;
          end else begin
            res.coef_write = 1'b1;
            res.coef_index = coef_cnt_q;
            res.coef_value = {s1_word_q.rx_byte, low_q};
            coef_cnt_d     = coef_cnt_q + 1'b1;
          end
          byte_cnt_d   = byte_cnt_q + 1'b1;
          res.tx_valid = 1'b1;
          res.tx_byte  = ccbd_pkg::OpLoad;
        end else begin
          // byte after the last pair turns the PWM on
          pwm_d      = 1'b1;
          cmd_d      = ccbd_pkg::CMD_IDLE;
          byte_cnt_d = '0;
          coef_cnt_d = '0;
        end
      end
      ccbd_pkg::CMD_REF: begin
        if (byte_cnt_q == ccbd_pkg::CountW'(1)) begin
          low_d        = s1_word_q.rx_byte;
          byte_cnt_d   = ccbd_pkg::CountW'(2);
          res.tx_valid = 1'b1;
          res.tx_byte  = ccbd_pkg::OpRef;
        end else begin
          res.ref_write = 1'b1;
          res.ref_value = {s1_word_q.rx_byte, low_q};
          cmd_d         = ccbd_pkg::CMD_IDLE;
          byte_cnt_d    = '0;
          coef_cnt_d    = '0;
        end
      end
      ccbd_pkg::CMD_READ: begin
        res.tx_valid = 1'b1;
        res.tx_byte  = low_q;
        cmd_d        = ccbd_pkg::CMD_IDLE;
        byte_cnt_d   = '0;
        coef_cnt_d   = '0;
      end
      default: begin
        cmd_d      = ccbd_pkg::CMD_IDLE;
        byte_cnt_d = '0;
        coef_cnt_d = '0;
      end
    endcase
    res.pwm_enable = pwm_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cmd_q       <= ccbd_pkg::CMD_IDLE;
      byte_cnt_q  <= '0;
      coef_cnt_q  <= '0;
      low_q       <= '0;
      pwm_q       <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
        cmd_q       <= cmd_d;
        byte_cnt_q  <= byte_cnt_d;
        coef_cnt_q  <= coef_cnt_d;
        low_q       <= low_d;
        pwm_q       <= pwm_d;
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_word_q <= in_word_i;
    end
    if (s1_move) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`ifndef SYNTH
  // idle decoder holds no position within a command
  a_idle_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_q == ccbd_pkg::CMD_IDLE |-> byte_cnt_q == '0 && coef_cnt_q == '0)
    else $error("idle with nonzero counters");

  a_coef_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_word_q.coef_write |->
      32'(out_word_q.coef_index) < NUM_COEFS)
    else $error("coefficient index out of range");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_word_q.coef_write && out_word_q.ref_write))
    else $error("coefficient and reference write together");

  a_ref_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_word_q.ref_write |-> !out_word_q.tx_valid)
    else $error("reference write with transmit");

  a_pwm_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_word_q.pwm_enable == pwm_q)
    else $error("result pwm state differs from register");
`endif

endmodule

`default_nettype wire
